[src/mtes_pkg.sv]
// Package for the multi-timer expiry scanner.
// Holds the time constants, result kind codes and the stored entry type.
// No dependencies.
package mtes_pkg;

  localparam int unsigned DEFAULT_SLOTS = 16;

  localparam int unsigned MS_PER_S  = 1000;
  localparam int unsigned US_PER_S  = 1000000;

  // x / 1000 == (x * DIV_MAGIC) >> DIV_SHIFT for every 32-bit x.
  localparam longint unsigned DIV_MAGIC = 64'd274877907;
  localparam int unsigned     DIV_SHIFT = 38;

  localparam int unsigned MS_W    = 31;
  localparam int unsigned TAG_W   = 16;
  localparam int unsigned SEC_W   = 32;
  localparam int unsigned US_W    = 20;
  localparam int unsigned PSEC_W  = 22;
  localparam int unsigned REM_W   = 10;
  localparam int unsigned KIND_W  = 2;

  localparam logic [KIND_W-1:0] KIND_ADD_OK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD_FULL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIRED    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE     = 2'd3;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic              periodic;
    logic [PSEC_W-1:0] per_s;
    logic [US_W-1:0]   per_us;
    logic [SEC_W-1:0]  dl_s;
    logic [US_W-1:0]   dl_us;
  } entry_t;

endpackage

[src/multi_timer_expiry_scanner.sv]
// Multi-timer expiry scanner: ordered timer table with add and tick commands.
// Add: the result strobe follows the S_DIV, S_REM, S_PUS and S_ARM states after accept; a full
// table answers on the next cycle. Tick: TIMER_SLOTS-deep entry memory scanned one entry per cycle;
// a fired word is held until the next firing or scan end.
// busy_o is high while a command is at work; results cannot be stalled by the receiver.
// Reset (rst_ni, asynchronous, active low) empties the table; entry memory is not cleared.
module multi_timer_expiry_scanner
  import mtes_pkg::*;
#(
  parameter int unsigned TIMER_SLOTS = DEFAULT_SLOTS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic              command_i,
  input  logic [MS_W-1:0]   interval_ms_i,
  input  logic              repeat_mode_i,
  input  logic [TAG_W-1:0]  timer_tag_i,
  input  logic [SEC_W-1:0]  now_seconds_i,
  input  logic [US_W-1:0]   now_micros_i,
  output logic              result_valid_o,
  output logic [KIND_W-1:0] result_kind_o,
  output logic [TAG_W-1:0]  fired_tag_o,
  output logic              last_of_run_o
);

  localparam int unsigned CNT_W = $clog2(TIMER_SLOTS + 1);
  localparam int unsigned IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(TIMER_SLOTS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_REM   = 3'd2;
  localparam logic [2:0] S_PUS   = 3'd3;
  localparam logic [2:0] S_ARM   = 3'd4;
  localparam logic [2:0] S_PRIME = 3'd5;
  localparam logic [2:0] S_SCAN  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] rptr_q, rptr_d;
  logic [CNT_W-1:0] wptr_q, wptr_d;
  logic [CNT_W-1:0] sidx_q, sidx_d;
  logic             pend_v_q, pend_v_d;
  logic [TAG_W-1:0] pend_tag_q, pend_tag_d;

  // Latched command word.
  logic [MS_W-1:0]   ms_q;
  logic              mode_q;
  logic [TAG_W-1:0]  tag_q;
  logic [SEC_W-1:0]  now_s_q;
  logic [US_W-1:0]   now_us_q;
  logic [PSEC_W-1:0] quot_q, quot_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [US_W-1:0]   pus_q, pus_d;

  logic              res_v_d;
  logic [KIND_W-1:0] res_kind_d;
  logic [TAG_W-1:0]  res_tag_d;
  logic              res_last_d;

  // Entry memory, one write and one registered read port.
  entry_t            mem [TIMER_SLOTS];
  entry_t            rd_q;
  logic [IDX_W-1:0]  rd_idx;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  entry_t            wr_data;

  logic accept;
  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != S_IDLE);

  assign rd_idx = (rptr_q < SLOTS_C) ? rptr_q[IDX_W-1:0] : '0;

  // Shared re-arm unit: deadline = now + period with microsecond carry and saturation.
  logic [PSEC_W-1:0] arm_per_s;
  logic [US_W-1:0]   arm_per_us;
  logic [US_W:0]     us_sum;
  logic              us_carry;
  logic [SEC_W:0]    s_sum;
  logic [SEC_W-1:0]  arm_s;
  logic [US_W-1:0]   arm_us;

  always_comb begin
    arm_per_s  = (state_q == S_ARM) ? quot_q : rd_q.per_s;
    arm_per_us = (state_q == S_ARM) ? pus_q  : rd_q.per_us;
    us_sum     = {1'b0, now_us_q} + {1'b0, arm_per_us};
    us_carry   = (us_sum >= (US_W+1)'(US_PER_S));
    if (us_carry) begin
      us_sum = us_sum - (US_W+1)'(US_PER_S);
    end
    s_sum  = {1'b0, now_s_q} + (SEC_W+1)'(arm_per_s) + (SEC_W+1)'(us_carry);
    arm_s  = s_sum[SEC_W] ? '1 : s_sum[SEC_W-1:0];
    arm_us = us_sum[US_W-1:0];
  end

  // Expiry compare on the entry read out of the memory.
  logic due;
  always_comb begin
    if (now_s_q == rd_q.dl_s) begin
      due = (now_us_q >= rd_q.dl_us);
    end else begin
      due = (now_s_q > rd_q.dl_s);
    end
  end

  // Millisecond split datapath.
  logic [59:0] div_prod;
  logic [31:0] q_times_k;
  logic [19:0] rem_times_k;
  always_comb begin
    div_prod    = 60'(ms_q) * 60'(DIV_MAGIC);
    quot_d      = div_prod[DIV_SHIFT +: PSEC_W];
    q_times_k   = 32'(quot_q) * 32'(MS_PER_S);
    rem_d       = REM_W'(32'(ms_q) - q_times_k);
    rem_times_k = 20'(rem_q) * 20'(MS_PER_S);
    pus_d       = rem_times_k;
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    rptr_d     = rptr_q;
    wptr_d     = wptr_q;
    sidx_d     = sidx_q;
    pend_v_d   = pend_v_q;
    pend_tag_d = pend_tag_q;
    res_v_d    = 1'b0;
    res_kind_d = KIND_NONE;
    res_tag_d  = '0;
    res_last_d = 1'b0;
    wr_en      = 1'b0;
    wr_idx     = wptr_q[IDX_W-1:0];
    wr_data    = rd_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (command_i == CMD_TICK) begin
            state_d  = S_PRIME;
            rptr_d   = '0;
            wptr_d   = '0;
            sidx_d   = '0;
            pend_v_d = 1'b0;
          end else if (count_q >= SLOTS_C) begin
            res_v_d    = 1'b1;
            res_kind_d = KIND_ADD_FULL;
            res_last_d = 1'b1;
          end else begin
            state_d = S_DIV;
          end
        end
      end
      S_DIV: state_d = S_REM;
      S_REM: state_d = S_PUS;
      S_PUS: state_d = S_ARM;
      S_ARM: begin
        wr_en            = 1'b1;
        wr_idx           = count_q[IDX_W-1:0];
        wr_data.tag      = tag_q;
        wr_data.periodic = mode_q;
        wr_data.per_s    = quot_q;
        wr_data.per_us   = pus_q;
        wr_data.dl_s     = arm_s;
        wr_data.dl_us    = arm_us;
        count_d          = count_q + 1'b1;
        res_v_d          = 1'b1;
        res_kind_d       = KIND_ADD_OK;
        res_last_d       = 1'b1;
        state_d          = S_IDLE;
      end
      S_PRIME: begin
        rptr_d  = rptr_q + 1'b1;
        state_d = (count_q == '0) ? S_DONE : S_SCAN;
      end
      S_SCAN: begin
        rptr_d = rptr_q + 1'b1;
        sidx_d = sidx_q + 1'b1;
        if (due) begin
          // The previous firing is now known not to be the last one.
          if (pend_v_q) begin
            res_v_d    = 1'b1;
            res_kind_d = KIND_FIRED;
            res_tag_d  = pend_tag_q;
          end
          pend_v_d   = 1'b1;
          pend_tag_d = rd_q.tag;
        end
        // Kept entries are written back in order, which compacts the table.
        if (!due || rd_q.periodic) begin
          wr_en  = 1'b1;
          wptr_d = wptr_q + 1'b1;
          if (due) begin
            wr_data.dl_s  = arm_s;
            wr_data.dl_us = arm_us;
          end
        end
        if (CNT_W'(sidx_q + 1'b1) == count_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        res_v_d    = 1'b1;
        res_last_d = 1'b1;
        if (pend_v_q) begin
          res_kind_d = KIND_FIRED;
          res_tag_d  = pend_tag_q;
        end
        count_d  = wptr_q;
        pend_v_d = 1'b0;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      count_q        <= '0;
      rptr_q         <= '0;
      wptr_q         <= '0;
      sidx_q         <= '0;
      pend_v_q       <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      count_q        <= count_d;
      rptr_q         <= rptr_d;
      wptr_q         <= wptr_d;
      sidx_q         <= sidx_d;
      pend_v_q       <= pend_v_d;
      result_valid_o <= res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_tag_q    <= pend_tag_d;
    result_kind_o <= res_kind_d;
    fired_tag_o   <= res_tag_d;
    last_of_run_o <= res_last_d;
    quot_q        <= quot_d;
    rem_q         <= rem_d;
    pus_q         <= pus_d;
    if (accept) begin
      ms_q     <= interval_ms_i;
      mode_q   <= repeat_mode_i;
      tag_q    <= timer_tag_i;
      now_s_q  <= now_seconds_i;
      now_us_q <= now_micros_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_q <= mem[rd_idx];
  end

  // Assertions.
  a_tick_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && command_i == CMD_TICK) |=> busy_o)
    else $error("tick accepted but block not busy");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= SLOTS_C)
    else $error("entry count above table size");

  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (wptr_q <= sidx_q && sidx_q < count_q))
    else $error("write pointer ran ahead of scan pointer");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_of_run_o) |-> !busy_o)
    else $error("block busy after final result of a command");

endmodule

[verif/multi_timer_expiry_scanner_test.sv]
// Self-checking testbench for the multi-timer expiry scanner.
// Drives add and tick commands, predicts every result word and checks each strobe.
// Depends on mtes_pkg and multi_timer_expiry_scanner.
`timescale 1ns / 100ps

module multi_timer_expiry_scanner_test;
  import mtes_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned MAX_GAP        = 60;
  localparam int unsigned PERIODIC_CAP   = 5;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TAG_W-1:0]  tag;
    logic              last;
  } timer_result_t;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              start_i        = 1'b0;
  logic              command_i      = CMD_ADD;
  logic [MS_W-1:0]   interval_ms_i  = '0;
  logic              repeat_mode_i  = 1'b0;
  logic [TAG_W-1:0]  timer_tag_i    = '0;
  logic [SEC_W-1:0]  now_seconds_i  = '0;
  logic [US_W-1:0]   now_micros_i   = '0;
  logic              busy_o;
  logic              result_valid_o;
  logic [KIND_W-1:0] result_kind_o;
  logic [TAG_W-1:0]  fired_tag_o;
  logic              last_of_run_o;

  // Shadow copy of the timer table.
  entry_t          timer_table [DEFAULT_SLOTS];
  int unsigned     timer_count = 0;
  timer_result_t   expected_results [$];
  timer_result_t   want_result;

  int unsigned     mismatch_count  = 0;
  int unsigned     sender_idle_pct = 0;
  int unsigned     stall_cycles;
  logic [SEC_W-1:0] wall_s  = 32'd1000;
  logic [US_W-1:0]  wall_us = '0;

  multi_timer_expiry_scanner uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .command_i      (command_i),
    .interval_ms_i  (interval_ms_i),
    .repeat_mode_i  (repeat_mode_i),
    .timer_tag_i    (timer_tag_i),
    .now_seconds_i  (now_seconds_i),
    .now_micros_i   (now_micros_i),
    .result_valid_o (result_valid_o),
    .result_kind_o  (result_kind_o),
    .fired_tag_o    (fired_tag_o),
    .last_of_run_o  (last_of_run_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic entry_t arm_entry(entry_t e, logic [SEC_W-1:0] ns, logic [US_W-1:0] nus);
    logic [US_W:0]    us_sum;
    logic [SEC_W+1:0] s_sum;
    us_sum = {1'b0, nus} + {1'b0, e.per_us};
    s_sum  = {2'b00, ns} + {12'd0, e.per_s};
    if (us_sum >= US_PER_S) begin
      us_sum = us_sum - (US_W+1)'(US_PER_S);
      s_sum  = s_sum + 1'b1;
    end
    // Seconds saturate instead of wrapping.
    if (s_sum > {2'b00, {SEC_W{1'b1}}}) s_sum = {2'b00, {SEC_W{1'b1}}};
    e.dl_s  = s_sum[SEC_W-1:0];
    e.dl_us = us_sum[US_W-1:0];
    return e;
  endfunction

  function automatic logic entry_due(entry_t e, logic [SEC_W-1:0] ns, logic [US_W-1:0] nus);
    if (ns == e.dl_s) return nus >= e.dl_us;
    return ns > e.dl_s;
  endfunction

  function automatic int unsigned periodic_entries();
    int unsigned n;
    n = 0;
    for (int unsigned k = 0; k < timer_count; k++) n += timer_table[k].periodic;
    return n;
  endfunction

  // Appends one predicted result word to the expected queue.
  task automatic queue_expected(input logic [KIND_W-1:0] kind, input logic [TAG_W-1:0] tag,
                                input logic last);
    timer_result_t r;
    r.kind = kind;
    r.tag  = tag;
    r.last = last;
    expected_results.insert(expected_results.size(), r);
  endtask

  task automatic predict_timer_results(input logic cmd, input logic [MS_W-1:0] ms,
                                       input logic mode, input logic [TAG_W-1:0] tag,
                                       input logic [SEC_W-1:0] ns, input logic [US_W-1:0] nus);
    entry_t           fresh;
    logic [TAG_W-1:0] fired_tags [DEFAULT_SLOTS];
    int unsigned      n_fired;
    int unsigned      idx;
    n_fired = 0;
    if (cmd == CMD_ADD) begin
      if (timer_count >= DEFAULT_SLOTS) begin
        queue_expected(KIND_ADD_FULL, '0, 1'b1);
      end else begin
        fresh.tag      = tag;
        fresh.periodic = mode;
        fresh.per_s    = PSEC_W'(ms / MS_PER_S);
        fresh.per_us   = US_W'((ms % MS_PER_S) * MS_PER_S);
        fresh.dl_s     = '0;
        fresh.dl_us    = '0;
        timer_table[timer_count] = arm_entry(fresh, ns, nus);
        timer_count++;
        queue_expected(KIND_ADD_OK, '0, 1'b1);
      end
    end else begin
      idx = 0;
      while (idx < timer_count) begin
        if (!entry_due(timer_table[idx], ns, nus)) begin
          idx++;
        end else begin
          fired_tags[n_fired] = timer_table[idx].tag;
          n_fired++;
          if (!timer_table[idx].periodic) begin
            // A fired one-shot entry is removed and the rest slide down.
            for (int unsigned j = idx; j + 1 < timer_count; j++) timer_table[j] = timer_table[j + 1];
            timer_count--;
          end else begin
            timer_table[idx] = arm_entry(timer_table[idx], ns, nus);
            idx++;
          end
        end
      end
      if (n_fired == 0) begin
        queue_expected(KIND_NONE, '0, 1'b1);
      end else begin
        for (int unsigned k = 0; k < n_fired; k++)
          queue_expected(KIND_FIRED, fired_tags[k], k == n_fired - 1);
      end
    end
  endtask

  // Presents one command word, waits for it to be taken, then idles at random.
  task automatic send_word(input logic cmd, input logic [MS_W-1:0] ms, input logic mode,
                           input logic [TAG_W-1:0] tag, input logic [SEC_W-1:0] ns,
                           input logic [US_W-1:0] nus);
    int unsigned gap;
    @(negedge clk_i);
    start_i       <= 1'b1;
    command_i     <= cmd;
    interval_ms_i <= ms;
    repeat_mode_i <= mode;
    timer_tag_i   <= tag;
    now_seconds_i <= ns;
    now_micros_i  <= nus;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predict_timer_results(cmd, ms, mode, tag, ns, nus);
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic test_empty_tick();
    send_word(CMD_TICK, '0, 1'b0, '0, '0, '0);
  endtask

  task automatic test_field_limits();
    send_word(CMD_ADD, '0, 1'b0, '0, '0, '0);
    // Largest interval at the latest time: the deadline seconds saturate.
    send_word(CMD_ADD, {MS_W{1'b1}}, 1'b1, {TAG_W{1'b1}}, {SEC_W{1'b1}}, 20'd999999);
    // Microseconds beyond one second are taken as given.
    send_word(CMD_ADD, 31'd999, 1'b0, 16'h1234, 32'd5, {US_W{1'b1}});
    send_word(CMD_TICK, '0, 1'b0, '0, '0, '0);
    send_word(CMD_TICK, '0, 1'b0, '0, 32'd6, 20'd1047574);
    send_word(CMD_TICK, '0, 1'b0, '0, 32'd6, 20'd1047575);
    send_word(CMD_TICK, '0, 1'b0, '0, {SEC_W{1'b1}}, {US_W{1'b1}});
  endtask

  task automatic test_table_full();
    while (timer_count < DEFAULT_SLOTS)
      send_word(CMD_ADD, MS_W'($urandom_range(0, 5000)), 1'b0,
                TAG_W'($urandom_range(0, 65535)), 32'd10, '0);
    send_word(CMD_ADD, 31'd100, 1'b0, 16'hBEEF, 32'd10, '0);
    // Every entry is due at the latest time, so this tick fires the whole table.
    send_word(CMD_TICK, '0, 1'b0, '0, {SEC_W{1'b1}}, {US_W{1'b1}});
  endtask

  task automatic send_random_word();
    int unsigned pick;
    int unsigned step;
    int unsigned us_next;
    logic        mode;
    pick = $urandom_range(0, 99);
    mode = ($urandom_range(0, 99) < 30) && (periodic_entries() < PERIODIC_CAP);
    if (pick < 3) begin
      send_word(CMD_TICK, MS_W'($urandom()), mode, TAG_W'($urandom_range(0, 65535)),
                {SEC_W{1'b1}}, {US_W{1'b1}});
    end else if (pick < 25) begin
      send_word(1'($urandom_range(0, 1)), MS_W'($urandom()), mode,
                TAG_W'($urandom_range(0, 65535)), $urandom(),
                US_W'($urandom_range(0, 20'hF_FFFF)));
    end else if (pick < 60) begin
      send_word(CMD_ADD, MS_W'($urandom_range(0, 4000)), mode,
                TAG_W'($urandom_range(0, 65535)), wall_s, wall_us);
    end else begin
      // Time moves forward between ticks so that timers come due.
      step    = $urandom_range(0, 3000);
      us_next = wall_us + (step % 1000) * 1000;
      wall_s  = wall_s + step / 1000;
      if (us_next >= US_PER_S) begin
        us_next = us_next - US_PER_S;
        wall_s  = wall_s + 1;
      end
      wall_us = US_W'(us_next);
      send_word(CMD_TICK, MS_W'($urandom_range(0, 4000)), mode,
                TAG_W'($urandom_range(0, 65535)), wall_s, wall_us);
    end
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned words);
    sender_idle_pct = idle_pct;
    repeat (words) send_random_word();
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result word: kind %0d, fired_tag %0h", result_kind_o, fired_tag_o);
        mismatch_count++;
      end else begin
        want_result = expected_results.pop_front();
        if (result_kind_o !== want_result.kind) begin
          $error("result_kind: expected %0d, got %0d", want_result.kind, result_kind_o);
          mismatch_count++;
        end
        if (fired_tag_o !== want_result.tag) begin
          $error("fired_tag: expected %0h, got %0h", want_result.tag, fired_tag_o);
          mismatch_count++;
        end
        if (last_of_run_o !== want_result.last) begin
          $error("last_of_run: expected %0d, got %0d", want_result.last, last_of_run_o);
          mismatch_count++;
        end
      end
    end
  end

  // Ends the run if neither a command nor a result moves for too long.
  initial begin
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((start_i && !busy_o) || result_valid_o) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    sender_idle_pct = 29;
    test_empty_tick();
    test_field_limits();
    test_table_full();
    test_random_traffic(29, 86);
    test_random_traffic(81, 85);
    test_random_traffic(0, 85);
    @(negedge clk_i);
    start_i <= 1'b0;
    while (expected_results.size() != 0 || busy_o) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
